// ----- hw/rtl/lru_page_replacement_assert.svh -----
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define LRUPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lrupr_pkg.sv -----
`default_nettype none

package lrupr_pkg;

  localparam int AGE_W   = 16;
  localparam int FAULT_W = 16;
  localparam int CFG_W   = 4;
  localparam int OUT_PAGE_W = 16;
  localparam int OUT_IDX_W  = 3;

  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd8;

  // Search record that walks down the cell row.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             free_found;
    logic [AGE_W-1:0] best_age;
  } probe_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lrupr_cell.sv -----
`default_nettype none

module lrupr_cell #(
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 3,
  parameter int INDEX     = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          age_en,
  input  wire                          active,
  input  wire        [PAGE_BITS-1:0]   look_page,
  input  wire   lrupr_pkg::probe_t     probe_in,
  input  wire        [IDX_W-1:0]       where_in,
  input  wire        [IDX_W-1:0]       free_in,
  input  wire        [IDX_W-1:0]       best_in,
  input  wire        [PAGE_BITS-1:0]   best_page_in,
  output lrupr_pkg::probe_t            probe_out,
  output logic       [IDX_W-1:0]       where_out,
  output logic       [IDX_W-1:0]       free_out,
  output logic       [IDX_W-1:0]       best_out,
  output logic       [PAGE_BITS-1:0]   best_page_out,
  input  wire                          wr_en,
  input  wire        [IDX_W-1:0]       wr_idx,
  input  wire        [PAGE_BITS-1:0]   wr_page
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_BITS-1:0]            page;
  logic                            valid;
  logic [lrupr_pkg::AGE_W-1:0]     age;

  logic                            match;
  lrupr_pkg::probe_t               probe_next;
  logic [IDX_W-1:0]                where_next;
  logic [IDX_W-1:0]                free_next;
  logic [IDX_W-1:0]                best_next;
  logic [PAGE_BITS-1:0]            best_page_next;

  always_comb begin
    match          = active && valid && (page == look_page);
    probe_next     = probe_in;
    where_next     = where_in;
    free_next      = free_in;
    best_next      = best_in;
    best_page_next = best_page_in;
    // lowest matching frame is the one reported
    if (match && !probe_in.found) begin
      where_next = MY_IDX;
    end
    probe_next.found = probe_in.found | match;
    if (active && !valid && !probe_in.free_found) begin
      probe_next.free_found = 1'b1;
      free_next             = MY_IDX;
    end
    // strict compare keeps ties on the lower index
    if (active && (age > probe_in.best_age)) begin
      probe_next.best_age = age;
      best_next           = MY_IDX;
      best_page_next      = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out     <= probe_next;
      where_out     <= where_next;
      free_out      <= free_next;
      best_out      <= best_next;
      best_page_out <= best_page_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page  <= '0;
      valid <= 1'b0;
      age   <= '0;
    end else if (wr_en && (wr_idx == MY_IDX)) begin
      page  <= wr_page;
      valid <= 1'b1;
      age   <= '0;
    end else if (probe_in.valid && match) begin
      age <= '0;
    end else if (age_en && active && (age != lrupr_pkg::AGE_MAX)) begin
      age <= age + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_page_replacement.sv -----
`default_nettype none

// LRU page replacement with per-frame age counters. Raise start with a page
// number while busy is low; the access is taken at that edge and busy rises.
// All active frames age at once, then a search beat walks the row of frame
// cells one cell per cycle. Busy drops in the cycle that done is shown.
// The result sits on hit, frame_index, evicted_valid, evicted_page and
// fault_count for the single cycle that done is high; nothing holds it, so
// capture it then. frames_in_use (APB, address 0) picks how many low frames
// take part; 0 acts as 1 and values above FRAMES act as FRAMES. Write it only
// while busy is low.

module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] page_number,
  output logic        done,
  output logic        hit,
  output logic [2:0]  frame_index,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [15:0] fault_count,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use;
  logic [lrupr_pkg::FAULT_W-1:0] faults_seen;
  logic [lrupr_pkg::FAULT_W-1:0] faults_next;
  logic [PAGE_BITS-1:0]          req_page;
  logic                          accept;
  logic                          cfg_wr;
  logic [FRAMES-1:0]             active;

  lrupr_pkg::probe_t             chain [FRAMES+1];
  logic [IDX_W-1:0]              where_c [FRAMES+1];
  logic [IDX_W-1:0]              free_c [FRAMES+1];
  logic [IDX_W-1:0]              best_c [FRAMES+1];
  logic [PAGE_BITS-1:0]          best_page_c [FRAMES+1];

  lrupr_pkg::probe_t             tail;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == lrupr_pkg::REG_FRAMES_IN_USE);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == lrupr_pkg::REG_FRAMES_IN_USE) begin
      prdata = 32'(frames_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (i < int'(frames_in_use));
    end
  end

  // head of the row: a fresh search beat
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid      <= accept;
      chain[0].found      <= 1'b0;
      chain[0].free_found <= 1'b0;
      chain[0].best_age   <= '0;
      where_c[0]          <= '0;
      free_c[0]           <= '0;
      best_c[0]           <= '0;
      best_page_c[0]      <= '0;
    end
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .age_en        (accept),
      .active        (active[g]),
      .look_page     (req_page),
      .probe_in      (chain[g]),
      .where_in      (where_c[g]),
      .free_in       (free_c[g]),
      .best_in       (best_c[g]),
      .best_page_in  (best_page_c[g]),
      .probe_out     (chain[g+1]),
      .where_out     (where_c[g+1]),
      .free_out      (free_c[g+1]),
      .best_out      (best_c[g+1]),
      .best_page_out (best_page_c[g+1]),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_page       (req_page)
    );
  end

  assign tail   = chain[FRAMES];
  assign wr_en  = tail.valid && !tail.found;
  assign wr_idx = tail.free_found ? free_c[FRAMES] : best_c[FRAMES];

  always_comb begin
    faults_next = faults_seen;
    if (!tail.found && (faults_seen != lrupr_pkg::FAULT_MAX)) begin
      faults_next = faults_seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done          <= 1'b0;
      faults_seen   <= '0;
      frames_in_use <= lrupr_pkg::FRAMES_IN_USE_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        frames_in_use <= pwdata[lrupr_pkg::CFG_W-1:0];
      end
      if (accept) begin
        busy     <= 1'b1;
        req_page <= PAGE_BITS'(page_number);
      end
      if (tail.valid) begin
        busy        <= 1'b0;
        done        <= 1'b1;
        faults_seen <= faults_next;
        fault_count <= faults_next;
        hit         <= tail.found;
        if (tail.found) begin
          frame_index   <= lrupr_pkg::OUT_IDX_W'(where_c[FRAMES]);
          evicted_valid <= 1'b0;
          evicted_page  <= '0;
        end else if (tail.free_found) begin
          frame_index   <= lrupr_pkg::OUT_IDX_W'(free_c[FRAMES]);
          evicted_valid <= 1'b0;
          evicted_page  <= '0;
        end else begin
          frame_index   <= lrupr_pkg::OUT_IDX_W'(best_c[FRAMES]);
          evicted_valid <= 1'b1;
          evicted_page  <= lrupr_pkg::OUT_PAGE_W'(best_page_c[FRAMES]);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lrupr_checker.sv -----
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lrupr_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        hit,
  input wire        evicted_valid,
  input wire [15:0] evicted_page,
  input wire [15:0] fault_count
);

  `LRUPR_ASSERT_NEXT(a_take_sets_busy, clk, rst, start && !busy, busy, "busy did not rise after accept")
  `LRUPR_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held for two cycles")
  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk, rst, done && hit, !evicted_valid && (evicted_page == 16'd0), "hit reported an eviction")
  `LRUPR_ASSERT_NOW(a_no_evict_zero, clk, rst, done && !evicted_valid, evicted_page == 16'd0, "evicted page not zero")
  `LRUPR_ASSERT_NOW(a_fault_counted, clk, rst, done && !hit, fault_count != 16'd0, "fault not counted")

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

`default_nettype wire

// ----- tb/tb_lru_page_replacement.sv -----
`timescale 1ns / 1ps

module tb_lru_page_replacement;

  localparam int FRAMES          = 8;
  localparam int PAGE_BITS       = 16;
  localparam int CLK_HALF        = 5;
  localparam int ACCESS_LATENCY  = FRAMES + 2;
  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int DRAIN_LIMIT     = 10_000;
  localparam int RANDOM_ITEMS    = 1550;
  localparam int RANDOM_PHASES   = 8;
  localparam int ONE_FRAME_ITEMS = 16;

  localparam logic [2:0] ADDR_FRAMES   = {lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = {~lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};

  typedef struct packed {
    logic        hit;
    logic [2:0]  frame;
    logic        ev_valid;
    logic [15:0] ev_page;
    logic [15:0] faults;
  } lru_result_t;

  // Tracks residency and ages of every frame and queues the outcome of each access.
  class lru_scoreboard;
    localparam int FRAME_COUNT = 8;

    logic [15:0] frame_page [FRAME_COUNT];
    bit          frame_valid [FRAME_COUNT];
    logic [15:0] frame_age [FRAME_COUNT];
    logic [15:0] faults;
    logic [3:0]  frames_cfg;
    lru_result_t outcome_q [$];
    int          mismatches;
    int          accesses;
    int          hits;
    int          evictions;

    function new();
      for (int j = 0; j < FRAME_COUNT; j++) begin
        frame_page[j]  = '0;
        frame_valid[j] = 1'b0;
        frame_age[j]   = '0;
      end
      faults     = '0;
      frames_cfg = lrupr_pkg::FRAMES_IN_USE_RESET;
      mismatches = 0;
      accesses   = 0;
      hits       = 0;
      evictions  = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void set_frames(logic [3:0] value);
      frames_cfg = value;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_access(logic [15:0] pg);
      int          n;
      int          where;
      bit          found;
      bit          have_free;
      logic [15:0] best;
      lru_result_t r;
      n = frames_cfg;
      if (n < 1) n = 1;
      if (n > FRAME_COUNT) n = FRAME_COUNT;
      found = 1'b0;
      have_free = 1'b0;
      where = 0;
      r = '0;
      for (int j = 0; j < n; j++) begin
        if (frame_age[j] != lrupr_pkg::AGE_MAX) frame_age[j]++;
      end
      // Clear every matching frame; report the lowest one.
      for (int j = 0; j < n; j++) begin
        if (frame_valid[j] && frame_page[j] == pg) begin
          frame_age[j] = '0;
          if (!found) where = j;
          found = 1'b1;
        end
      end
      if (found) begin
        hits++;
      end else begin
        if (faults != lrupr_pkg::FAULT_MAX) faults++;
        for (int j = 0; j < n; j++) begin
          if (!have_free && !frame_valid[j]) begin
            where = j;
            have_free = 1'b1;
          end
        end
        if (!have_free) begin
          // Oldest wins; strict compare keeps the lowest index on ties.
          best = '0;
          where = 0;
          for (int j = 0; j < n; j++) begin
            if (frame_age[j] > best) begin
              best = frame_age[j];
              where = j;
            end
          end
          r.ev_valid = 1'b1;
          r.ev_page = frame_page[where];
          evictions++;
        end
        frame_page[where]  = pg;
        frame_valid[where] = 1'b1;
        frame_age[where]   = '0;
      end
      accesses++;
      r.hit    = found;
      r.frame  = 3'(where);
      r.faults = faults;
      outcome_q.push_back(r);
    endfunction

    task check_result(input lru_result_t got);
      lru_result_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("result beat with no access waiting (frame %0d)", got.frame));
        return;
      end
      want = outcome_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit: got %b want %b", got.hit, want.hit));
      if (got.frame !== want.frame)
        report($sformatf("frame_index: got %0d want %0d", got.frame, want.frame));
      if (got.ev_valid !== want.ev_valid)
        report($sformatf("evicted_valid: got %b want %b", got.ev_valid, want.ev_valid));
      if (got.ev_page !== want.ev_page)
        report($sformatf("evicted_page: got %h want %h", got.ev_page, want.ev_page));
      if (got.faults !== want.faults)
        report($sformatf("fault_count: got %0d want %0d", got.faults, want.faults));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] page_number;
  logic        done;
  logic        hit;
  logic [2:0]  frame_index;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [15:0] fault_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_result_t   dut_result;
  lru_scoreboard sb;
  int            cycles;
  int            cfg_writes;

  assign dut_result = {hit, frame_index, evicted_valid, evicted_page, fault_count};

  lru_page_replacement #(
    .FRAMES(FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .page_number(page_number),
    .done(done),
    .hit(hit),
    .frame_index(frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .fault_count(fault_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
  end

  always #(CLK_HALF) clk = ~clk;

  initial begin
    sb = new();
    cycles = 0;
    cfg_writes = 0;
  end

  // Check the finishing beat before noting a new one taken at the same edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lru_page_replacement verification failed");
      $finish;
    end
    if (!rst) begin
      if (done) sb.check_result(dut_result);
      if (start && !busy) sb.note_access(page_number);
    end
  end

  // With a nonzero gap, drop start, wait until the block is free and then idle
  // for the gap; then hold the beat until it is taken.
  task automatic send_page(input logic [15:0] pg, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    page_number <= pg;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0 || busy) @(posedge clk);
    repeat (ACCESS_LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == lrupr_pkg::REG_FRAMES_IN_USE) sb.set_frames(data[3:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_writes++;
  endtask

  task automatic check_frames_readback();
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_FRAMES;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[3:0] !== sb.frames_cfg)
      sb.report($sformatf("frames_in_use readback: got %0d want %0d", rd[3:0], sb.frames_cfg));
  endtask

  task automatic write_frames_in_use(input logic [3:0] value);
    wait_idle();
    apb_write(ADDR_FRAMES, {28'($urandom), value});
    check_frames_readback();
  endtask

  initial begin
    logic [15:0] pool [16];
    logic [15:0] pg;
    int          pool_n;
    int          idle_pct;
    int          gap;
    int          waited;
    logic [3:0]  cfg;

    rst <= 1'b1;
    start <= 1'b0;
    page_number <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: page 0 into empty frames, fill, evict, then shrink and regrow.
    check_frames_readback();
    send_page(16'h0000, 0);
    send_page(16'h0000, 0);
    send_page(16'hFFFF, 0);
    send_page(16'h5555, 0);
    send_page(16'hAAAA, 0);
    send_page(16'h0001, 0);
    send_page(16'h8000, 0);
    send_page(16'h1234, 0);
    send_page(16'hFEDC, 0);
    send_page(16'h0F0F, 0);
    send_page(16'hAAAA, 3);
    write_frames_in_use(4'd0);
    send_page(16'h0000, 0);
    send_page(16'h5555, 0);
    send_page(16'h5555, 0);
    write_frames_in_use(4'd15);
    // Frames 0 and 2 both hold the same page now.
    send_page(16'h5555, 0);
    send_page(16'h2468, 0);
    wait_idle();
    apb_write(ADDR_UNMAPPED, 32'h0000_0002);
    check_frames_readback();
    send_page(16'hF0F0, 0);
    write_frames_in_use(4'd3);
    send_page(16'h0F0F, 0);
    send_page(16'h7777, 1);
    send_page(16'h1234, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: cfg = 4'd8;
        1: cfg = 4'd1;
        2: cfg = 4'd15;
        3: cfg = 4'd0;
        default: cfg = 4'($urandom_range(0, 15));
      endcase
      write_frames_in_use(cfg);
      pool_n = $urandom_range(2, 16);
      for (int k = 0; k < pool_n; k++) begin
        case ($urandom_range(0, 7))
          0: pool[k] = 16'h0000;
          1: pool[k] = 16'hFFFF;
          default: pool[k] = 16'($urandom);
        endcase
      end
      idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : 25 * $urandom_range(0, 2);
      for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
        pg = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                          : 16'($urandom);
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 10) : 0;
        send_page(pg, gap);
      end
    end

    // One active frame and a new page every beat: every access after the first faults.
    write_frames_in_use(4'd1);
    pg = 16'h0000;
    for (int i = 0; i < ONE_FRAME_ITEMS; i++) begin
      send_page(pg, 0);
      pg = pg + 16'd1;
    end

    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (ACCESS_LATENCY + 4) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("covered %0d accesses: %0d hits, %0d evictions, %0d register writes",
             sb.accesses, sb.hits, sb.evictions, cfg_writes);
    $display("frame counts from zero to fifteen, shared pages after regrowth; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_cell.sv
hw/rtl/lru_page_replacement.sv
hw/rtl/lrupr_checker.sv
tb/tb_lru_page_replacement.sv
